// File: hdl/arc_pkg.sv
package arc_pkg;

    localparam int unsigned ADDR_W = 64;
    localparam int unsigned NUM_CLASSES = 4;
    localparam int unsigned CAT_W = 2;
    localparam int unsigned REGION_W = 3;
    localparam int unsigned TOTAL_W = 6;
    localparam int unsigned ARC_RANGES_PER_CLASS = 8;

    localparam logic [REGION_W-1:0] CLASS_UNKNOWN = 3'd4;

    typedef enum logic [1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_INSERT   = 2'd1,
        CMD_CLASSIFY = 2'd2
    } arc_cmd_t;

    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] range_start;
        logic [ADDR_W-1:0] range_end;
    } arc_entry_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } arc_ctrl_t;

endpackage

// File: hdl/arc_cell.sv
module arc_cell
    import arc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  arc_ctrl_t         ctrl,
    input  arc_entry_t        prev,
    input  logic [ADDR_W-1:0] query,
    output arc_entry_t        entry,
    output logic              hit
);

    logic              vld_reg;
    logic              vld_next;
    logic [ADDR_W-1:0] start_reg;
    logic [ADDR_W-1:0] start_next;
    logic [ADDR_W-1:0] stop_reg;
    logic [ADDR_W-1:0] stop_next;

    always_comb
    begin
        vld_next   = vld_reg;
        start_next = start_reg;
        stop_next  = stop_reg;
        if (ctrl.clear)
        begin
            vld_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            vld_next   = prev.vld;
            start_next = prev.range_start;
            stop_next  = prev.range_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        stop_reg  <= stop_next;
    end

    assign entry.vld         = vld_reg;
    assign entry.range_start = start_reg;
    assign entry.range_end   = stop_reg;

    assign hit = vld_reg && (query >= start_reg) && (query < stop_reg);

endmodule

// File: hdl/arc_chain.sv
module arc_chain
    import arc_pkg::*;
#(
    parameter int unsigned DEPTH = ARC_RANGES_PER_CLASS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  arc_ctrl_t         ctrl,
    input  arc_entry_t        new_entry,
    input  logic [ADDR_W-1:0] query,
    output logic              full,
    output logic              hit
);

    arc_entry_t             entries [DEPTH];
    logic       [DEPTH-1:0] hits;

    // new ranges enter at the head and older ones move one cell along
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        arc_entry_t prev;
        if (i == 0)
        begin : g_head
            assign prev = new_entry;
        end
        else
        begin : g_body
            assign prev = entries[i-1];
        end

        arc_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .prev  (prev),
            .query (query),
            .entry (entries[i]),
            .hit   (hits[i])
        );
    end

    assign full = entries[DEPTH-1].vld;
    assign hit  = |hits;

endmodule

// File: hdl/address_region_classifier_core.sv
// channel | direction | fields
// in      | to core   | cmd, category, range_start, range_end, query_addr
// out     | from core | region_class, insert_full, total_ranges
//
// one word per cycle unless stalled; request register, then result register
// the cycle is set by the two 64-bit compares inside each range cell
// reset clears every cell's valid flag and the range count; no clearing pass
// in_stall rises only while the held word waits on a stalled result register

module address_region_classifier_core
    import arc_pkg::*;
#(
    parameter int unsigned RANGES_PER_CLASS = ARC_RANGES_PER_CLASS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          cmd,
    input  logic [CAT_W-1:0]    category,
    input  logic [ADDR_W-1:0]   range_start,
    input  logic [ADDR_W-1:0]   range_end,
    input  logic [ADDR_W-1:0]   query_addr,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [REGION_W-1:0] region_class,
    output logic                insert_full,
    output logic [TOTAL_W-1:0]  total_ranges
);

    localparam int unsigned CNT_W = $clog2(NUM_CLASSES * RANGES_PER_CLASS + 1);

    logic                req_vld_reg;
    logic                req_vld_next;
    arc_cmd_t            cmd_reg;
    logic [CAT_W-1:0]    cat_reg;
    logic [ADDR_W-1:0]   rs_reg;
    logic [ADDR_W-1:0]   re_reg;
    logic [ADDR_W-1:0]   qa_reg;

    logic                out_vld_reg;
    logic                out_vld_next;
    logic [REGION_W-1:0] region_reg;
    logic [REGION_W-1:0] region_next;
    logic                full_reg;
    logic                full_next;
    logic [TOTAL_W-1:0]  tot_out_reg;
    logic [TOTAL_W-1:0]  tot_out_next;

    logic [CNT_W-1:0]    total_reg;
    logic [CNT_W-1:0]    total_next;
    logic [CNT_W+TOTAL_W-1:0] total_ext;

    logic                advance;
    logic                exec;
    logic                in_accept;

    arc_ctrl_t             ctrl     [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] cat_full;
    logic [NUM_CLASSES-1:0] cat_hit;
    arc_entry_t            new_entry;

    assign advance   = !out_vld_reg || !out_stall;
    assign exec      = req_vld_reg && advance;
    assign in_stall  = req_vld_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    assign new_entry.vld         = 1'b1;
    assign new_entry.range_start = rs_reg;
    assign new_entry.range_end   = re_reg;

    for (genvar c = 0; c < NUM_CLASSES; c++)
    begin : g_class
        assign ctrl[c].clear = exec && (cmd_reg == CMD_CLEAR);
        assign ctrl[c].shift = exec && (cmd_reg == CMD_INSERT)
                               && (cat_reg == CAT_W'(c)) && !cat_full[c];

        arc_chain #(
            .DEPTH (RANGES_PER_CLASS)
        ) u_chain (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl[c]),
            .new_entry (new_entry),
            .query     (qa_reg),
            .full      (cat_full[c]),
            .hit       (cat_hit[c])
        );
    end

    always_comb
    begin
        region_next = CLASS_UNKNOWN;
        full_next   = 1'b0;
        total_next  = total_reg;
        case (cmd_reg)
            CMD_CLEAR:
            begin
                total_next = '0;
            end
            CMD_INSERT:
            begin
                if (cat_full[cat_reg])
                begin
                    full_next = 1'b1;
                end
                else
                begin
                    total_next = total_reg + CNT_W'(1);
                end
            end
            CMD_CLASSIFY:
            begin
                // highest priority is the lowest category number
                for (int c = NUM_CLASSES - 1; c >= 0; c--)
                begin
                    if (cat_hit[c])
                    begin
                        region_next = REGION_W'(c);
                    end
                end
            end
            default:
            begin
                total_next = total_reg;
            end
        endcase
    end

    assign total_ext    = {{TOTAL_W{1'b0}}, total_next};
    assign tot_out_next = total_ext[TOTAL_W-1:0];

    assign req_vld_next = in_accept || (req_vld_reg && !exec);
    assign out_vld_next = exec || (out_vld_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            total_reg   <= '0;
        end
        else
        begin
            req_vld_reg <= req_vld_next;
            out_vld_reg <= out_vld_next;
            if (exec)
            begin
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg <= arc_cmd_t'(cmd);
            cat_reg <= category;
            rs_reg  <= range_start;
            re_reg  <= range_end;
            qa_reg  <= query_addr;
        end
        if (exec)
        begin
            region_reg  <= region_next;
            full_reg    <= full_next;
            tot_out_reg <= tot_out_next;
        end
    end

    assign out_valid    = out_vld_reg;
    assign region_class = region_reg;
    assign insert_full  = full_reg;
    assign total_ranges = tot_out_reg;

endmodule
